[hdl/assert_macros.svh]
// Assertion macros shared by the branch unit RTL.
// Every check samples on clk and stays quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge out of reset
`define BRU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("branch unit assertion failed");

// Expression must never be true out of reset
`define BRU_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("branch unit forbidden condition");

`endif

[hdl/bru_pkg.sv]
// Types, codes and constants of the IA-64 branch unit.
// Used by bru_state, bru_exec and ia64_branch_unit; depends on nothing.
package bru_pkg;

  localparam int unsigned XLEN  = 64;
  localparam int unsigned IW    = 37;
  localparam int unsigned CFM_W = 37;
  localparam int unsigned NBR   = 8;
  localparam int unsigned BR_IW = 3;

  // Item kinds
  typedef enum logic [2:0] {
    ACT_EXEC = 3'd0,
    ACT_WBR  = 3'd1,
    ACT_WLC  = 3'd2,
    ACT_WEC  = 3'd3,
    ACT_WIP  = 3'd4,
    ACT_WCFM = 3'd5,
    ACT_WPFS = 3'd6
  } action_t;

  // Branch unit opcodes as decoded upstream
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_BREAK = 3'd1,
    OP_IND   = 3'd2,
    OP_REL   = 3'd3,
    OP_RCALL = 3'd4,
    OP_ICALL = 3'd5
  } unit_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_UNIMPL  = 2'd2,
    ST_BREAK   = 2'd3
  } status_t;

  // Relative branch types (btype field)
  localparam logic [2:0] BT_COND  = 3'd0;
  localparam logic [2:0] BT_WEXIT = 3'd2;
  localparam logic [2:0] BT_WTOP  = 3'd3;
  localparam logic [2:0] BT_CLOOP = 3'd5;
  localparam logic [2:0] BT_CEXIT = 3'd6;
  localparam logic [2:0] BT_CTOP  = 3'd7;

  // Indirect opcodes: {x6, btype}
  localparam logic [8:0] OPC_BR_COND = 9'(8'h20 * 8 + 0);
  localparam logic [8:0] OPC_BR_IA   = 9'(8'h20 * 8 + 1);
  localparam logic [8:0] OPC_BR_RET  = 9'(8'h21 * 8 + 4);

  localparam logic [XLEN-1:0] TGT_MASK    = ~64'd15;
  localparam logic [XLEN-1:0] LINK_OFFSET = 64'd16;
  localparam int unsigned     PFS_EC_LO   = 52;

  typedef struct packed {
    logic [2:0]      action;
    logic [2:0]      unit_op;
    logic [IW-1:0]   instr_word;
    logic            qp_true;
    logic [BR_IW-1:0] reg_index;
    logic [XLEN-1:0] write_data;
  } item_t;

  typedef struct packed {
    status_t         status;
    logic            taken;
    logic [XLEN-1:0] next_ip;
    logic            rotate;
    logic            p63_write;
    logic            p63_value;
    logic            push_frame;
    logic            pop_frame;
    logic [XLEN-1:0] loop_count;
    logic [XLEN-1:0] epilog_count;
  } result_t;

  // Architectural scalar state
  typedef struct packed {
    logic [XLEN-1:0]  ip;
    logic [XLEN-1:0]  lc;
    logic [XLEN-1:0]  ec;
    logic [XLEN-1:0]  pfs;
    logic [CFM_W-1:0] cfm;
  } arch_state_t;

  // Branch register write port
  typedef struct packed {
    logic             we;
    logic [BR_IW-1:0] idx;
    logic [XLEN-1:0]  data;
  } br_wr_t;

endpackage

[hdl/ia64_branch_unit.sv]
// IA-64 branch unit, top level: input register, execute logic, result register.
// Depends on bru_pkg, bru_state, bru_exec and assert_macros.svh.
//
// Usage:
//  - Input channel (in_*): one word per item, either a branch-unit instruction
//    to execute (with its qualifying predicate value) or a setup write of a
//    branch register, LC, EC, IP, CFM or PFS. Taken when in_valid && !in_stall.
//  - Result channel (out_*): exactly one word per item: status, taken flag,
//    IP/LC/EC after the item and the rotate, p63, push and pop flags.
//    Taken when out_valid && !out_stall.
//  - An accepted item is held in the input register and then moves to the
//    result register. Throughput: one item per cycle while out_stall is low;
//    state is updated when an item moves from the input register to the
//    result register, so the next item sees it without a gap.
//  - Reset (rst_n low, synchronous): both registers empty, IP, LC, EC, PFS,
//    CFM and all branch registers cleared.
//  - Receiver stall: the result register holds; one more item can wait in the
//    input register, after which in_stall rises until the result is taken.
module ia64_branch_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [2:0]  in_unit_op,
  input  logic [36:0] in_instr_word,
  input  logic        in_qp_true,
  input  logic [2:0]  in_reg_index,
  input  logic [63:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_taken,
  output logic [63:0] out_next_ip,
  output logic        out_rotate,
  output logic        out_p63_write,
  output logic        out_p63_value,
  output logic        out_push_frame,
  output logic        out_pop_frame,
  output logic [63:0] out_loop_count_out,
  output logic [63:0] out_epilog_count_out
);

`include "assert_macros.svh"

  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  bru_pkg::item_t                s1_item_r;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  bru_pkg::result_t              out_res_r;
  logic                          out_free;
  logic                          commit;
  logic                          accept;
  bru_pkg::arch_state_t          st_cur;
  bru_pkg::arch_state_t          st_nxt;
  bru_pkg::br_wr_t               br_wr;
  logic [bru_pkg::BR_IW-1:0]     br_rd_idx;
  logic [bru_pkg::XLEN-1:0]      br_rd_data;
  bru_pkg::result_t              res;

  // Handshake control
  assign out_free      = !out_valid_r || !out_stall;
  assign commit        = s1_valid_r && out_free;
  assign in_stall      = s1_valid_r && !out_free;
  assign accept        = in_valid && !in_stall;
  assign s1_valid_nxt  = accept || (s1_valid_r && !commit);
  assign out_valid_nxt = commit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= '{action:     in_action,
                     unit_op:    in_unit_op,
                     instr_word: in_instr_word,
                     qp_true:    in_qp_true,
                     reg_index:  in_reg_index,
                     write_data: in_write_data};
    end
  end

  bru_exec u_exec (
    .item       (s1_item_r),
    .st_cur     (st_cur),
    .br_rd_data (br_rd_data),
    .br_rd_idx  (br_rd_idx),
    .st_nxt     (st_nxt),
    .br_wr      (br_wr),
    .res        (res)
  );

  bru_state u_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (commit),
    .st_nxt     (st_nxt),
    .br_wr      (br_wr),
    .br_rd_idx  (br_rd_idx),
    .st_cur     (st_cur),
    .br_rd_data (br_rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (commit) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_res_r.status;
  assign out_taken            = out_res_r.taken;
  assign out_next_ip          = out_res_r.next_ip;
  assign out_rotate           = out_res_r.rotate;
  assign out_p63_write        = out_res_r.p63_write;
  assign out_p63_value        = out_res_r.p63_value;
  assign out_push_frame       = out_res_r.push_frame;
  assign out_pop_frame        = out_res_r.pop_frame;
  assign out_loop_count_out   = out_res_r.loop_count;
  assign out_epilog_count_out = out_res_r.epilog_count;

  // Checks
  `BRU_ASSERT(a_stall_only_when_full, in_stall |-> s1_valid_r)
  `BRU_NEVER(a_fault_not_taken, out_valid_r && out_res_r.status != bru_pkg::ST_OK && out_res_r.taken)
  `BRU_NEVER(a_push_pop_excl, out_valid_r && out_res_r.push_frame && out_res_r.pop_frame)
  `BRU_ASSERT(a_rotate_p63, out_valid_r && out_res_r.rotate |-> out_res_r.p63_write)
  `BRU_ASSERT(a_commit_fills_out, commit |=> out_valid_r)

endmodule

[hdl/bru_state.sv]
// Architectural state of the branch unit: IP, LC, EC, PFS, CFM and BR0-7.
// Depends on bru_pkg; loaded from bru_exec's next state on each commit.
module bru_state (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             commit,
  input  bru_pkg::arch_state_t             st_nxt,
  input  bru_pkg::br_wr_t                  br_wr,
  input  logic [bru_pkg::BR_IW-1:0]        br_rd_idx,
  output bru_pkg::arch_state_t             st_cur,
  output logic [bru_pkg::XLEN-1:0]         br_rd_data
);

  bru_pkg::arch_state_t st_r;
  logic [bru_pkg::XLEN-1:0] br_r [bru_pkg::NBR];

  // Scalar registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (commit) begin
      st_r <= st_nxt;
    end
  end

  // Branch register file, one write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bru_pkg::NBR; i++) begin
        br_r[i] <= '0;
      end
    end else if (commit && br_wr.we) begin
      br_r[br_wr.idx] <= br_wr.data;
    end
  end

  assign st_cur     = st_r;
  assign br_rd_data = br_r[br_rd_idx];

endmodule

[hdl/bru_exec.sv]
// Single-pass execute logic: decodes one word and forms result and next state.
// Depends on bru_pkg; purely combinational, state comes from bru_state.
module bru_exec (
  input  bru_pkg::item_t                   item,
  input  bru_pkg::arch_state_t             st_cur,
  input  logic [bru_pkg::XLEN-1:0]         br_rd_data,
  output logic [bru_pkg::BR_IW-1:0]        br_rd_idx,
  output bru_pkg::arch_state_t             st_nxt,
  output bru_pkg::br_wr_t                  br_wr,
  output bru_pkg::result_t                 res
);

  logic [bru_pkg::IW-1:0]   w;
  logic [2:0]               bt;
  logic [8:0]               opc;
  logic                     qpf_nz;
  logic [bru_pkg::XLEN-1:0] disp;
  logic [bru_pkg::XLEN-1:0] rel_tgt;
  logic [bru_pkg::XLEN-1:0] ind_tgt;
  logic [bru_pkg::XLEN-1:0] link;
  logic [bru_pkg::XLEN-1:0] pfs_save;
  logic [bru_pkg::XLEN-1:0] lc_dec;
  logic [bru_pkg::XLEN-1:0] ec_dec;
  logic                     lc_nz;
  logic                     ec_gt1;
  logic                     ec_one;
  logic                     is_top;
  logic                     tk;

  // Instruction fields and shared arithmetic
  assign w         = item.instr_word;
  assign bt        = w[8:6];
  assign opc       = {w[32:27], w[8:6]};
  assign qpf_nz    = (w[5:0] != 6'd0);
  assign br_rd_idx = w[15:13];
  assign disp      = {{40{w[36]}}, w[32:13], 4'b0000};
  assign rel_tgt   = st_cur.ip + disp;
  assign ind_tgt   = br_rd_data & bru_pkg::TGT_MASK;
  assign link      = st_cur.ip + bru_pkg::LINK_OFFSET;
  assign pfs_save  = {6'd0, st_cur.ec[5:0], 15'd0, st_cur.cfm};
  assign lc_dec    = st_cur.lc - 64'd1;
  assign ec_dec    = st_cur.ec - 64'd1;
  assign lc_nz     = (st_cur.lc != '0);
  assign ec_gt1    = (st_cur.ec > 64'd1);
  assign ec_one    = (st_cur.ec == 64'd1);
  assign is_top    = bt[0];

  always_comb begin
    st_nxt         = st_cur;
    br_wr          = '0;
    res            = '0;
    res.status     = bru_pkg::ST_OK;
    tk             = 1'b0;

    case (bru_pkg::action_t'(item.action))
      bru_pkg::ACT_WBR: begin
        br_wr.we   = 1'b1;
        br_wr.idx  = item.reg_index;
        br_wr.data = item.write_data;
      end
      bru_pkg::ACT_WLC:  st_nxt.lc  = item.write_data;
      bru_pkg::ACT_WEC:  st_nxt.ec  = item.write_data;
      bru_pkg::ACT_WIP:  st_nxt.ip  = item.write_data;
      bru_pkg::ACT_WCFM: st_nxt.cfm = item.write_data[bru_pkg::CFM_W-1:0];
      bru_pkg::ACT_WPFS: st_nxt.pfs = item.write_data;
      bru_pkg::ACT_EXEC: begin
        case (bru_pkg::unit_op_t'(item.unit_op))
          bru_pkg::OP_NOP: ;
          bru_pkg::OP_BREAK: begin
            if (item.qp_true) res.status = bru_pkg::ST_BREAK;
          end
          // Indirect branches through a branch register
          bru_pkg::OP_IND: begin
            case (opc)
              bru_pkg::OPC_BR_COND: begin
                if (item.qp_true) begin
                  st_nxt.ip = ind_tgt;
                  res.taken = 1'b1;
                end
              end
              bru_pkg::OPC_BR_IA: res.status = bru_pkg::ST_UNIMPL;
              bru_pkg::OPC_BR_RET: begin
                if (item.qp_true) begin
                  st_nxt.ip     = ind_tgt;
                  st_nxt.cfm    = st_cur.pfs[bru_pkg::CFM_W-1:0];
                  st_nxt.ec     = {58'd0, st_cur.pfs[bru_pkg::PFS_EC_LO +: 6]};
                  res.pop_frame = 1'b1;
                  res.taken     = 1'b1;
                end
              end
              default: res.status = bru_pkg::ST_ILLEGAL;
            endcase
          end
          // IP-relative branches and loop branches
          bru_pkg::OP_REL: begin
            if ((bt inside {bru_pkg::BT_CLOOP, bru_pkg::BT_CEXIT, bru_pkg::BT_CTOP})
                && qpf_nz) begin
              res.status = bru_pkg::ST_ILLEGAL;
            end else begin
              case (bt)
                bru_pkg::BT_COND: begin
                  if (item.qp_true) begin
                    st_nxt.ip = rel_tgt;
                    res.taken = 1'b1;
                  end
                end
                bru_pkg::BT_CLOOP: begin
                  if (lc_nz) begin
                    st_nxt.lc = lc_dec;
                    st_nxt.ip = rel_tgt;
                    res.taken = 1'b1;
                  end
                end
                bru_pkg::BT_CEXIT, bru_pkg::BT_CTOP,
                bru_pkg::BT_WEXIT, bru_pkg::BT_WTOP: begin
                  res.p63_write = 1'b1;
                  if (bt[2] ? lc_nz : item.qp_true) begin
                    // kernel: counted loops also consume LC and set p63
                    if (bt[2]) begin
                      st_nxt.lc     = lc_dec;
                      res.p63_value = 1'b1;
                    end
                    res.rotate = 1'b1;
                    tk         = is_top;
                  end else if (ec_gt1) begin
                    st_nxt.ec  = ec_dec;
                    res.rotate = 1'b1;
                    tk         = is_top;
                  end else if (ec_one) begin
                    st_nxt.ec  = '0;
                    res.rotate = 1'b1;
                    tk         = !is_top;
                  end else begin
                    tk         = !is_top;
                  end
                  res.taken = tk;
                  if (tk) st_nxt.ip = rel_tgt;
                end
                default: res.status = bru_pkg::ST_ILLEGAL;
              endcase
            end
          end
          // Calls: save link and PFS, push a frame
          bru_pkg::OP_RCALL, bru_pkg::OP_ICALL: begin
            if (item.qp_true) begin
              br_wr.we       = 1'b1;
              br_wr.idx      = w[8:6];
              br_wr.data     = link;
              st_nxt.ip      = (item.unit_op == bru_pkg::OP_RCALL) ? rel_tgt : ind_tgt;
              st_nxt.pfs     = pfs_save;
              res.push_frame = 1'b1;
              res.taken      = 1'b1;
            end
          end
          default: res.status = bru_pkg::ST_ILLEGAL;
        endcase
      end
      default: ;
    endcase

    res.next_ip      = st_nxt.ip;
    res.loop_count   = st_nxt.lc;
    res.epilog_count = st_nxt.ec;
  end

endmodule

[test/testbench.sv]
// Self-checking testbench for ia64_branch_unit: directed table, then random words.
// A local model of IP, LC, EC, PFS, CFM and branch registers predicts untyped results.
// Depends on bru_pkg and the ia64_branch_unit RTL.
module testbench;

  // Codes the package leaves unnamed
  localparam logic [2:0] ACT_NONE = 3'd7;
  localparam logic [2:0] OP_BAD_A = 3'd6;
  localparam logic [2:0] OP_BAD_B = 3'd7;
  localparam logic [2:0] BT_BAD_B = 3'd4;
  localparam logic [8:0] OPC_BAD  = {6'h3f, 3'd7};
  localparam logic [2:0] REL_BTS [6] = '{bru_pkg::BT_COND, bru_pkg::BT_WEXIT,
                                         bru_pkg::BT_WTOP, bru_pkg::BT_CLOOP,
                                         bru_pkg::BT_CEXIT, bru_pkg::BT_CTOP};

  localparam int WORDS_PER_PHASE = 100;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    bru_pkg::item_t   it;
    bit               typed;
    bru_pkg::result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_action;
  logic [2:0]  in_unit_op;
  logic [36:0] in_instr_word;
  logic        in_qp_true;
  logic [2:0]  in_reg_index;
  logic [63:0] in_write_data;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        out_taken;
  logic [63:0] out_next_ip;
  logic        out_rotate;
  logic        out_p63_write;
  logic        out_p63_value;
  logic        out_push_frame;
  logic        out_pop_frame;
  logic [63:0] out_loop_count_out;
  logic [63:0] out_epilog_count_out;

  // Model of the architectural state
  logic [63:0] cur_ip;
  logic [63:0] loop_cnt;
  logic [63:0] epi_cnt;
  logic [63:0] pfs_val;
  logic [36:0] cfm_val;
  logic [63:0] bregs [8];

  bru_pkg::result_t pending_results [$];
  stim_row_t        dir_rows [$];

  int idle_pct;
  int stall_pct;
  int n_sent, n_checked, n_bad, n_extra, n_taken, n_loops, n_calls, n_rets, n_faults;

  ia64_branch_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_action            (in_action),
    .in_unit_op           (in_unit_op),
    .in_instr_word        (in_instr_word),
    .in_qp_true           (in_qp_true),
    .in_reg_index         (in_reg_index),
    .in_write_data        (in_write_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_taken            (out_taken),
    .out_next_ip          (out_next_ip),
    .out_rotate           (out_rotate),
    .out_p63_write        (out_p63_write),
    .out_p63_value        (out_p63_value),
    .out_push_frame       (out_push_frame),
    .out_pop_frame        (out_pop_frame),
    .out_loop_count_out   (out_loop_count_out),
    .out_epilog_count_out (out_epilog_count_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Instruction encoders
  function automatic logic [36:0] ind_word(logic [8:0] opc, logic [2:0] b2, logic [5:0] qpf);
    logic [36:0] w;
    w = '0;
    w[32:27] = opc[8:3];
    w[8:6]   = opc[2:0];
    w[15:13] = b2;
    w[5:0]   = qpf;
    return w;
  endfunction

  function automatic logic [36:0] rel_word(logic [2:0] bt, logic [19:0] imm, logic s,
                                           logic [5:0] qpf);
    logic [36:0] w;
    w = '0;
    w[36]    = s;
    w[32:13] = imm;
    w[8:6]   = bt;
    w[5:0]   = qpf;
    return w;
  endfunction

  // Calls: link gets IP+16, PFS saves CFM and the low EC bits
  function automatic void enter_call(logic [2:0] link, logic [63:0] target);
    bregs[link] = cur_ip + bru_pkg::LINK_OFFSET;
    cur_ip      = target;
    pfs_val     = {6'b0, epi_cnt[5:0], 15'b0, cfm_val};
  endfunction

  // Applies one word to the model state and returns the result it gives
  function automatic bru_pkg::result_t resolve_branch(bru_pkg::item_t it);
    bru_pkg::result_t r;
    logic [63:0]      disp;
    logic [63:0]      tgt;
    logic [8:0]       opc;
    logic [2:0]       bt;
    logic             top;
    logic             counted;
    r       = '0;
    r.status = bru_pkg::ST_OK;
    disp    = {{40{it.instr_word[36]}}, it.instr_word[32:13], 4'b0000};
    tgt     = cur_ip + disp;
    opc     = {it.instr_word[32:27], it.instr_word[8:6]};
    bt      = it.instr_word[8:6];
    counted = (bt == bru_pkg::BT_CLOOP || bt == bru_pkg::BT_CEXIT || bt == bru_pkg::BT_CTOP);
    top     = (bt == bru_pkg::BT_CTOP || bt == bru_pkg::BT_WTOP);
    case (it.action)
      bru_pkg::ACT_WBR:  bregs[it.reg_index] = it.write_data;
      bru_pkg::ACT_WLC:  loop_cnt = it.write_data;
      bru_pkg::ACT_WEC:  epi_cnt = it.write_data;
      bru_pkg::ACT_WIP:  cur_ip = it.write_data;
      bru_pkg::ACT_WCFM: cfm_val = it.write_data[36:0];
      bru_pkg::ACT_WPFS: pfs_val = it.write_data;
      bru_pkg::ACT_EXEC: begin
        case (it.unit_op)
          bru_pkg::OP_NOP: ;
          bru_pkg::OP_BREAK: if (it.qp_true) r.status = bru_pkg::ST_BREAK;
          bru_pkg::OP_IND: begin
            if (opc == bru_pkg::OPC_BR_COND) begin
              if (it.qp_true) begin
                cur_ip  = bregs[it.instr_word[15:13]] & bru_pkg::TGT_MASK;
                r.taken = 1'b1;
              end
            end else if (opc == bru_pkg::OPC_BR_IA) begin
              r.status = bru_pkg::ST_UNIMPL;
            end else if (opc == bru_pkg::OPC_BR_RET) begin
              if (it.qp_true) begin
                cur_ip      = bregs[it.instr_word[15:13]] & bru_pkg::TGT_MASK;
                cfm_val     = pfs_val[36:0];
                epi_cnt     = {58'b0, pfs_val[57:52]};
                r.pop_frame = 1'b1;
                r.taken     = 1'b1;
              end
            end else begin
              r.status = bru_pkg::ST_ILLEGAL;
            end
          end
          bru_pkg::OP_REL: begin
            // counted loops must be unpredicated
            if (counted && it.instr_word[5:0] != 6'd0) begin
              r.status = bru_pkg::ST_ILLEGAL;
            end else begin
              case (bt)
                bru_pkg::BT_COND: begin
                  if (it.qp_true) begin
                    cur_ip  = tgt;
                    r.taken = 1'b1;
                  end
                end
                bru_pkg::BT_CLOOP: begin
                  if (loop_cnt != 0) begin
                    loop_cnt = loop_cnt - 1;
                    cur_ip   = tgt;
                    r.taken  = 1'b1;
                  end
                end
                bru_pkg::BT_CEXIT, bru_pkg::BT_CTOP,
                bru_pkg::BT_WEXIT, bru_pkg::BT_WTOP: begin
                  // modulo-scheduled loops: kernel, then epilog drain on EC
                  r.p63_write = 1'b1;
                  if (counted ? (loop_cnt != 0) : it.qp_true) begin
                    if (counted) begin
                      loop_cnt    = loop_cnt - 1;
                      r.p63_value = 1'b1;
                    end
                    r.rotate = 1'b1;
                    r.taken  = top;
                  end else if (epi_cnt > 1) begin
                    epi_cnt  = epi_cnt - 1;
                    r.rotate = 1'b1;
                    r.taken  = top;
                  end else if (epi_cnt == 1) begin
                    epi_cnt  = '0;
                    r.rotate = 1'b1;
                    r.taken  = !top;
                  end else begin
                    r.taken = !top;
                  end
                  if (r.taken) cur_ip = tgt;
                end
                default: r.status = bru_pkg::ST_ILLEGAL;
              endcase
            end
          end
          bru_pkg::OP_RCALL: begin
            if (it.qp_true) begin
              enter_call(it.instr_word[8:6], tgt);
              r.push_frame = 1'b1;
              r.taken      = 1'b1;
            end
          end
          bru_pkg::OP_ICALL: begin
            if (it.qp_true) begin
              enter_call(it.instr_word[8:6],
                         bregs[it.instr_word[15:13]] & bru_pkg::TGT_MASK);
              r.push_frame = 1'b1;
              r.taken      = 1'b1;
            end
          end
          default: r.status = bru_pkg::ST_ILLEGAL;
        endcase
      end
      default: ;
    endcase
    r.next_ip      = cur_ip;
    r.loop_count   = loop_cnt;
    r.epilog_count = epi_cnt;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] act, logic [2:0] op, logic [36:0] w,
                                  logic qp, logic [2:0] idx, logic [63:0] data,
                                  bit typed, bru_pkg::status_t st);
    stim_row_t row;
    row.it.action     = act;
    row.it.unit_op    = op;
    row.it.instr_word = w;
    row.it.qp_true    = qp;
    row.it.reg_index  = idx;
    row.it.write_data = data;
    row.typed         = typed;
    row.want          = '0;
    row.want.status   = st;
    dir_rows.push_back(row);
  endfunction

  // Random word: mostly well-formed branches, setup writes with small counts, some noise
  function automatic bru_pkg::item_t rand_item();
    bru_pkg::item_t it;
    int             sel;
    int             pick;
    it.action     = bru_pkg::ACT_EXEC;
    it.unit_op    = bru_pkg::OP_NOP;
    it.instr_word = 37'({$urandom, $urandom});
    it.qp_true    = 1'($urandom);
    it.reg_index  = 3'($urandom);
    it.write_data = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sel < 14) begin
      it.action = (sel < 8) ? bru_pkg::ACT_WLC : bru_pkg::ACT_WEC;
      if ($urandom_range(0, 3) != 0) it.write_data = 64'($urandom_range(0, 3));
    end else if (sel < 18) begin
      it.action = bru_pkg::ACT_WBR;
      if ($urandom_range(0, 1) != 0) it.write_data[63:20] = '0;
    end else if (sel < 20) begin
      it.action = bru_pkg::ACT_WIP;
    end else if (sel < 22) begin
      it.action = bru_pkg::ACT_WCFM;
    end else if (sel < 24) begin
      it.action = bru_pkg::ACT_WPFS;
    end else if (sel < 27) begin
      it.action  = 3'($urandom);
      it.unit_op = 3'($urandom);
    end else if (sel < 31) begin
      it.unit_op = ($urandom_range(0, 1) != 0) ? bru_pkg::OP_BREAK : bru_pkg::OP_NOP;
    end else if (sel < 70) begin
      it.unit_op = bru_pkg::OP_REL;
      it.instr_word[8:6] = ($urandom_range(0, 9) == 0) ? 3'($urandom)
                                                       : REL_BTS[$urandom_range(0, 5)];
      if ($urandom_range(0, 9) != 0) it.instr_word[5:0] = '0;
    end else if (sel < 82) begin
      it.unit_op = bru_pkg::OP_IND;
      pick = $urandom_range(0, 9);
      if (pick < 4)
        it.instr_word = ind_word(bru_pkg::OPC_BR_COND, 3'($urandom), 6'($urandom));
      else if (pick < 7)
        it.instr_word = ind_word(bru_pkg::OPC_BR_RET, 3'($urandom), 6'($urandom));
      else if (pick < 8)
        it.instr_word = ind_word(bru_pkg::OPC_BR_IA, 3'($urandom), 6'($urandom));
      if ($urandom_range(0, 3) != 0) it.qp_true = 1'b1;
    end else begin
      it.unit_op = (sel < 92) ? bru_pkg::OP_RCALL : bru_pkg::OP_ICALL;
      if ($urandom_range(0, 3) != 0) it.qp_true = 1'b1;
    end
    return it;
  endfunction

  // Offer one word, hold it until accepted, then record its expected result
  task automatic send_word(bru_pkg::item_t it, bit typed, bru_pkg::result_t want);
    bru_pkg::result_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= it.action;
    in_unit_op    <= it.unit_op;
    in_instr_word <= it.instr_word;
    in_qp_true    <= it.qp_true;
    in_reg_index  <= it.reg_index;
    in_write_data <= it.write_data;
    do @(posedge clk); while (in_stall);
    r = resolve_branch(it);
    pending_results.push_back(typed ? want : r);
    n_sent++;
    @(negedge clk);
  endtask

  function automatic string fmt_result(bru_pkg::result_t r);
    return $sformatf("st=%0d tk=%0b ip=%h rot=%0b p63=%0b/%0b push=%0b pop=%0b lc=%h ec=%h",
                     r.status, r.taken, r.next_ip, r.rotate, r.p63_write, r.p63_value,
                     r.push_frame, r.pop_frame, r.loop_count, r.epilog_count);
  endfunction

  // Receiver stall
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result check against the oldest expectation
  initial begin
    bru_pkg::result_t got;
    bru_pkg::result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.status       = bru_pkg::status_t'(out_status);
        got.taken        = out_taken;
        got.next_ip      = out_next_ip;
        got.rotate       = out_rotate;
        got.p63_write    = out_p63_write;
        got.p63_value    = out_p63_value;
        got.push_frame   = out_push_frame;
        got.pop_frame    = out_pop_frame;
        got.loop_count   = out_loop_count_out;
        got.epilog_count = out_epilog_count_out;
        if (pending_results.size() == 0) begin
          n_extra++;
          if (n_bad + n_extra <= MAX_REPORTS)
            $display("%0t: result with none expected: %s", $realtime, fmt_result(got));
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (got !== want) begin
            n_bad++;
            if (n_bad + n_extra <= MAX_REPORTS) begin
              $display("%0t: mismatch on result %0d", $realtime, n_checked);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
          end
          if (want.taken) n_taken++;
          if (want.p63_write) n_loops++;
          if (want.push_frame) n_calls++;
          if (want.pop_frame) n_rets++;
          if (want.status != bru_pkg::ST_OK) n_faults++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("** ia64_branch_unit: FAILED **");
    $finish;
  end

  // Stimulus
  initial begin
    int               idle_tab  [4];
    int               stall_tab [4];
    bru_pkg::result_t none;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = bru_pkg::ACT_EXEC;
    in_unit_op    = bru_pkg::OP_NOP;
    in_instr_word = '0;
    in_qp_true    = 1'b0;
    in_reg_index  = '0;
    in_write_data = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    idle_tab      = '{0, 80, 0, 8};
    stall_tab     = '{0, 0, 80, 8};
    none          = '0;
    cur_ip        = '0;
    loop_cnt      = '0;
    epi_cnt       = '0;
    pfs_val       = '0;
    cfm_val       = '0;
    foreach (bregs[i]) bregs[i] = '0;

    // State is all zero here, so the first rows have obvious results
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_NOP, '0, 1'b1, '0, '0, 1, bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_BREAK, '0, 1'b1, '0, '0, 1, bru_pkg::ST_BREAK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_BREAK, '1, 1'b0, '0, '0, 1, bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, OP_BAD_A, '0, 1'b1, '0, '0, 1, bru_pkg::ST_ILLEGAL);
    add_row(bru_pkg::ACT_EXEC, OP_BAD_B, '1, 1'b0, '1, '1, 1, bru_pkg::ST_ILLEGAL);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_IND, ind_word(bru_pkg::OPC_BR_IA, 3'd0, 6'd0),
            1'b0, '0, '0, 1, bru_pkg::ST_UNIMPL);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_IND, ind_word(OPC_BAD, 3'd7, 6'd1), 1'b1, '0, '0,
            1, bru_pkg::ST_ILLEGAL);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_REL, rel_word(bru_pkg::BT_CTOP, '1, 1'b1, 6'd63),
            1'b1, '0, '0, 1, bru_pkg::ST_ILLEGAL);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_REL, rel_word(BT_BAD_B, '0, 1'b0, 6'd0), 1'b1,
            '0, '0, 1, bru_pkg::ST_ILLEGAL);
    add_row(ACT_NONE, bru_pkg::OP_NOP, '0, 1'b1, '1, '1, 1, bru_pkg::ST_OK);
    // Setup at the extremes, then every branch kind against the predictor
    add_row(bru_pkg::ACT_WBR, bru_pkg::OP_NOP, '0, 1'b0, 3'd7, '1, 0, bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_WBR, bru_pkg::OP_NOP, '0, 1'b0, 3'd0, 64'h1234_5678_9abc_def7, 0,
            bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_WLC, bru_pkg::OP_NOP, '0, 1'b0, '0, 64'd2, 0, bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_WEC, bru_pkg::OP_NOP, '0, 1'b0, '0, 64'd2, 0, bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_WIP, bru_pkg::OP_NOP, '0, 1'b0, '0, 64'hffff_ffff_ffff_fff0, 0,
            bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_WCFM, bru_pkg::OP_NOP, '0, 1'b0, '0, '1, 0, bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_WPFS, bru_pkg::OP_NOP, '0, 1'b0, '0, '1, 0, bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_REL, rel_word(bru_pkg::BT_COND, '1, 1'b0, 6'd5),
            1'b1, '0, '0, 0, bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_REL,
            rel_word(bru_pkg::BT_CTOP, 20'h00010, 1'b0, 6'd0), 1'b0, '0, '0, 0,
            bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_REL,
            rel_word(bru_pkg::BT_CEXIT, 20'h00020, 1'b0, 6'd0), 1'b0, '0, '0, 0,
            bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_REL, rel_word(bru_pkg::BT_CTOP, '1, 1'b1, 6'd0),
            1'b1, '0, '0, 0, bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_REL,
            rel_word(bru_pkg::BT_WTOP, 20'h00003, 1'b0, 6'd9), 1'b0, '0, '0, 0,
            bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_REL,
            rel_word(bru_pkg::BT_WEXIT, 20'h00004, 1'b1, 6'd9), 1'b0, '0, '0, 0,
            bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_REL,
            rel_word(bru_pkg::BT_CLOOP, 20'h00005, 1'b0, 6'd0), 1'b1, '0, '0, 0,
            bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_RCALL, rel_word(3'd3, 20'h80000, 1'b1, 6'd1),
            1'b1, '0, '0, 0, bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_ICALL, ind_word({6'h00, 3'd5}, 3'd7, 6'd2), 1'b1,
            '0, '0, 0, bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_IND, ind_word(bru_pkg::OPC_BR_COND, 3'd0, 6'd3),
            1'b1, '0, '0, 0, bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_IND, ind_word(bru_pkg::OPC_BR_RET, 3'd3, 6'd4),
            1'b1, '0, '0, 0, bru_pkg::ST_OK);
    add_row(bru_pkg::ACT_EXEC, bru_pkg::OP_IND, ind_word(bru_pkg::OPC_BR_RET, 3'd5, 6'd4),
            1'b0, '0, '0, 0, bru_pkg::ST_OK);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // Random words under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      repeat (WORDS_PER_PHASE) send_word(rand_item(), 0, none);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $write("Sent %0d words (%0d directed); checked %0d results: ",
           n_sent, dir_rows.size(), n_checked);
    $display("%0d taken, %0d loop, %0d call, %0d return, %0d faulting",
             n_taken, n_loops, n_calls, n_rets, n_faults);
    $display("Mismatches %0d, unexpected results %0d, results still owed %0d",
             n_bad, n_extra, pending_results.size());
    if (n_bad == 0 && n_extra == 0 && pending_results.size() == 0)
      $display("** ia64_branch_unit: PASSED **");
    else
      $display("** ia64_branch_unit: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/bru_pkg.sv
hdl/bru_state.sv
hdl/bru_exec.sv
hdl/ia64_branch_unit.sv
test/testbench.sv
